FILE: hdl/rhc_pkg.sv
package rhc_pkg;

   // One pixel in, one HSV triple out
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_type;

   // Widths of the two long divisions
   localparam int HUE_NUM_W = 11;                // numerator and 6d, both below 2048
   localparam int HUE_REM_W = HUE_NUM_W + 8;     // num*254 and the aligned divisor
   localparam int SAT_REM_W = 16;                // d*254 and the aligned max
   localparam int QUO_W     = 8;

   // Word carried through the divider stages
   typedef struct packed {
      logic                 grey;
      logic [7:0]           brightness;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_REM_W-1:0] hue_dsh;
      logic [QUO_W-1:0]     hue_q;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_REM_W-1:0] sat_dsh;
      logic [QUO_W-1:0]     sat_q;
   } div_word_type;

   // Number of divider stages, two quotient bits each
   localparam int DIV_STAGES = 4;

endpackage

FILE: hdl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter.
// Request channel: req_valid/req_stall with one pixel word (red, green, blue) per
// transfer. Response channel: rsp_valid/rsp_stall with one word (hue, saturation,
// brightness), each scaled to 0..254. Every request word gives exactly one
// response word, in order.
// Pipeline: six register stages.
// Throughput: one pixel per cycle when the response side does not stall. Two
// pipeline stages find max, min, chroma and the hue numerator and scale them;
// four divider stages then retire two quotient bits each for hue and saturation
// side by side. The last divider stage is the output register.
// Stall: the whole pipeline holds while a response word waits under rsp_stall,
// and req_stall is raised for that cycle; nothing is dropped or repeated.
// Reset: synchronous, clears every stage valid bit; req_stall is high during reset.
module rgb_to_hsv_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rhc_pkg::pixel_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rhc_pkg::hsv_type   rsp_word
);
   import rhc_pkg::*;

   logic         advance;
   logic         front_valid;
   div_word_type front_word;
   logic         stage_valid [DIV_STAGES+1];
   div_word_type stage_word  [DIV_STAGES+1];
   logic [DIV_STAGES:0] valid_vec;
   div_word_type last_word;

   // Pipeline moves when the output register is empty or being taken
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = reset || !advance;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (req_valid && !req_stall),
      .word_in   (req_word),
      .valid_out (front_valid),
      .word_out  (front_word)
   );

   assign stage_valid[0] = front_valid;
   assign stage_word[0]  = front_word;

   // Divider chain
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rhc_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .valid_in  (stage_valid[s]),
         .word_in   (stage_word[s]),
         .valid_out (stage_valid[s+1]),
         .word_out  (stage_word[s+1])
      );
   end

   always_comb begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         valid_vec[s] = stage_valid[s];
      end
   end

   // Grey pixels (zero chroma, black included) have zero hue and saturation
   assign last_word           = stage_word[DIV_STAGES];
   assign rsp_valid           = stage_valid[DIV_STAGES];
   assign rsp_word.hue        = last_word.grey ? 8'd0 : last_word.hue_q;
   assign rsp_word.saturation = last_word.grey ? 8'd0 : last_word.sat_q;
   assign rsp_word.brightness = last_word.brightness;

   // Results never leave the 0..254 range
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.hue <= 8'd254) && (rsp_word.saturation <= 8'd254)
                    && (rsp_word.brightness <= 8'd254))
      else $error("result out of range");

   // A held pipeline keeps every stage valid bit
   a_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_vec))
      else $error("stage valid changed while held");

   // An accepted word reaches the output when no stall holds the pipeline on its way
   a_latency : assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && !req_stall, 6) && $past(!req_stall, 5) && $past(!req_stall, 4)
       && $past(!req_stall, 3) && $past(!req_stall, 2) && $past(!req_stall, 1))
      |-> rsp_valid)
      else $error("response word missing after pipeline latency");

endmodule

FILE: hdl/rhc_front.sv
module rhc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  rhc_pkg::pixel_type    word_in,
   output logic                  valid_out,
   output rhc_pkg::div_word_type word_out
);
   import rhc_pkg::*;

   logic [7:0]           mx;
   logic [7:0]           mn;
   logic [7:0]           d;
   logic [HUE_NUM_W-1:0] hnum;
   logic [HUE_NUM_W-1:0] d_x;
   logic [HUE_NUM_W-1:0] r_x;
   logic [HUE_NUM_W-1:0] g_x;
   logic [HUE_NUM_W-1:0] b_x;

   logic                 s1_valid_ff;
   logic [7:0]           s1_mx_ff;
   logic [7:0]           s1_d_ff;
   logic [HUE_NUM_W-1:0] s1_hnum_ff;

   logic                 s2_valid_ff;
   div_word_type         s2_word_ff;
   div_word_type         s2_word_in;
   logic [HUE_NUM_W-1:0] six_d;

   // Stage 1: max, min, chroma and hue numerator
   always_comb begin
      mx = word_in.red;
      if (word_in.green > mx) mx = word_in.green;
      if (word_in.blue > mx) mx = word_in.blue;
      mn = word_in.red;
      if (word_in.green < mn) mn = word_in.green;
      if (word_in.blue < mn) mn = word_in.blue;
      d   = mx - mn;
      d_x = {3'b000, d};
      r_x = {3'b000, word_in.red};
      g_x = {3'b000, word_in.green};
      b_x = {3'b000, word_in.blue};
      // red wins ties over green, green over blue
      if (word_in.red == mx) begin
         if (word_in.green >= word_in.blue) begin
            hnum = g_x - b_x;
         end else begin
            hnum = (d_x << 2) + (d_x << 1) - (b_x - g_x);
         end
      end else if (word_in.green == mx) begin
         hnum = b_x + (d_x << 1) - r_x;
      end else begin
         hnum = r_x + (d_x << 2) - g_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_mx_ff   <= mx;
         s1_d_ff    <= d;
         s1_hnum_ff <= hnum;
      end
   end

   // Stage 2: scale numerators by 254 and align divisors to quotient bit 7
   always_comb begin
      six_d = ({3'b000, s1_d_ff} << 2) + ({3'b000, s1_d_ff} << 1);
      s2_word_in.grey       = (s1_d_ff == 8'd0);
      // mx*254/255 floors to mx-1 for every nonzero mx
      s2_word_in.brightness = (s1_mx_ff == 8'd0) ? 8'd0 : s1_mx_ff - 8'd1;
      s2_word_in.hue_rem    = {s1_hnum_ff, 8'h00} - {7'b0000000, s1_hnum_ff, 1'b0};
      s2_word_in.hue_dsh    = {1'b0, six_d, 7'b0000000};
      s2_word_in.hue_q      = '0;
      s2_word_in.sat_rem    = {s1_d_ff, 8'h00} - {7'b0000000, s1_d_ff, 1'b0};
      s2_word_in.sat_dsh    = {1'b0, s1_mx_ff, 7'b0000000};
      s2_word_in.sat_q      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign valid_out = s2_valid_ff;
   assign word_out  = s2_word_ff;

endmodule

FILE: hdl/rhc_div_stage.sv
module rhc_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  rhc_pkg::div_word_type word_in,
   output logic                  valid_out,
   output rhc_pkg::div_word_type word_out
);
   import rhc_pkg::*;

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in_next;
   logic         hue_bit;
   logic         sat_bit;

   // Two restoring steps for both divisions; divisors stay aligned, remainders shift up
   always_comb begin
      word_in_next = word_in;
      for (int i = 0; i < 2; i++) begin
         hue_bit = (word_in_next.hue_rem >= word_in_next.hue_dsh);
         if (hue_bit) begin
            word_in_next.hue_rem = word_in_next.hue_rem - word_in_next.hue_dsh;
         end
         word_in_next.hue_rem = word_in_next.hue_rem << 1;
         word_in_next.hue_q   = {word_in_next.hue_q[QUO_W-2:0], hue_bit};

         sat_bit = (word_in_next.sat_rem >= word_in_next.sat_dsh);
         if (sat_bit) begin
            word_in_next.sat_rem = word_in_next.sat_rem - word_in_next.sat_dsh;
         end
         word_in_next.sat_rem = word_in_next.sat_rem << 1;
         word_in_next.sat_q   = {word_in_next.sat_q[QUO_W-2:0], sat_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule

FILE: tb/tb.sv
module tb;
   import rhc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PIXELS  = 1600;
   localparam int DRAIN_CYCLES   = 16;

   // directed pixel with an optional hand-computed result
   typedef struct packed {
      pixel_type px;
      logic      fixed;
      hsv_type   hsv;
   } pixel_case_type;

   localparam pixel_case_type DIRECTED_PIXELS [18] = '{
      '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},  // black
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd254}},  // white
      '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd254, 8'd254}},  // pure red
      '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{8'd84,  8'd254, 8'd254}},  // pure green
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd169, 8'd254, 8'd254}},  // pure blue
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd127}},  // mid grey
      '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},  // darkest grey
      '{'{8'd255, 8'd255, 8'd0  }, 1'b0, '0},                         // red/green tie
      '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},                         // green/blue tie
      '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},                         // red/blue tie, wrap
      '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},                         // hue near top
      '{'{8'd1,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0},
      '{'{8'd255, 8'd254, 8'd255}, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd0  }, 1'b0, '0},
      '{'{8'd85,  8'd170, 8'd255}, 1'b0, '0},
      '{'{8'd1,   8'd2,   8'd3  }, 1'b0, '0},
      '{'{8'd254, 8'd255, 8'd253}, 1'b0, '0}
   };

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   pixel_type req_word  = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   hsv_type   rsp_word;

   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        mismatch_count = 0;
   hsv_type   hsv_due [$];

   rgb_to_hsv_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // exact integer HSV of one pixel
   function automatic hsv_type compute_hsv(input pixel_type px);
      int unsigned r, g, b, mx, mn, chroma, num;
      hsv_type     res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      chroma = mx - mn;
      res.brightness = 8'((mx * 254) / 255);
      res.saturation = (mx == 0) ? 8'd0 : 8'((chroma * 254) / mx);
      if (chroma == 0) begin
         res.hue = 8'd0;
      end else begin
         // ties go red, then green
         if (r == mx) begin
            num = (g >= b) ? g - b : 6 * chroma - (b - g);
         end else if (g == mx) begin
            num = b + 2 * chroma - r;
         end else begin
            num = r + 4 * chroma - g;
         end
         res.hue = 8'((num * 254) / (6 * chroma));
      end
      return res;
   endfunction

   // offer one pixel word, hold it until taken, then log its result
   task automatic send_pixel(input pixel_type px, input hsv_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hsv_due.push_back(want);
   endtask

   // hold off the sender until every pending result word is back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (hsv_due.size() != 0) @(posedge clock);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      hsv_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hsv_due.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = hsv_due.pop_front();
            if (rsp_word.hue !== want.hue) begin
               $display("%0t: hue expected %0d actual %0d", $time, want.hue, rsp_word.hue);
               mismatch_count++;
            end
            if (rsp_word.saturation !== want.saturation) begin
               $display("%0t: saturation expected %0d actual %0d",
                        $time, want.saturation, rsp_word.saturation);
               mismatch_count++;
            end
            if (rsp_word.brightness !== want.brightness) begin
               $display("%0t: brightness expected %0d actual %0d",
                        $time, want.brightness, rsp_word.brightness);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: ends the run after too long without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("rgb_to_hsv_converter: mismatch");
      $finish;
   end

   // stimulus
   initial begin
      pixel_type px;
      int        mode;
      int        pick;
      byte       level;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      foreach (DIRECTED_PIXELS[i]) begin
         send_pixel(DIRECTED_PIXELS[i].px,
                    DIRECTED_PIXELS[i].fixed ? DIRECTED_PIXELS[i].hsv
                                             : compute_hsv(DIRECTED_PIXELS[i].px));
      end
      settle_pipeline();

      // random pixels in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 53;
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PIXELS / 3) begin
            mode     = $urandom_range(99);
            level    = 8'($urandom_range(255));
            px.red   = 8'($urandom_range(255));
            px.green = 8'($urandom_range(255));
            px.blue  = 8'($urandom_range(255));
            if (mode < 15) begin
               // grey
               px = '{level, level, level};
            end else if (mode < 30) begin
               // two channels tie
               pick = $urandom_range(2);
               if (pick == 0) px.green = px.red;
               else if (pick == 1) px.blue = px.green;
               else px.blue = px.red;
            end else if (mode < 42) begin
               // channels at 0, 1, 254 or 255
               px.red   = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
               px.green = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
               px.blue  = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
            end
            send_pixel(px, compute_hsv(px));
         end
         settle_pipeline();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rgb_to_hsv_converter: match");
      end else begin
         $display("rgb_to_hsv_converter: mismatch");
      end
      $finish;
   end

endmodule
